// ===== rtl/lewr_pkg.sv =====
// Package for the line editor with word-wrapped cursor layout.
// Holds sizes, key codes, status and sequencer types and the blank test.
// No dependencies.
package lewr_pkg;

    localparam int TEXT_DEPTH = 2048;
    localparam int ADDR_W     = $clog2(TEXT_DEPTH);
    localparam int KEY_W      = 8;
    localparam int CHAR_W     = 7;
    localparam int WIDTH_W    = 8;
    localparam int LEN_OUT_W  = 11;
    localparam int ROW_W      = 11;
    localparam int COL_W      = 8;
    localparam int STATUS_W   = 2;

    localparam logic [ADDR_W-1:0] MAX_LEN = ADDR_W'(TEXT_DEPTH - 1);

    localparam logic [KEY_W-1:0] KEY_ERASE  = 8'h7F;
    localparam logic [KEY_W-1:0] KEY_KILL   = 8'h15;
    localparam logic [KEY_W-1:0] KEY_WORD   = 8'h17;
    localparam logic [KEY_W-1:0] KEY_EOF    = 8'h04;
    localparam logic [KEY_W-1:0] PRINT_LOW  = 8'd32;
    localparam logic [KEY_W-1:0] PRINT_HIGH = 8'd126;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'd32;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 7'd9;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 8'd40;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_BELL = 2'd1,
        STATUS_EXIT = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WSCAN,
        S_LAYOUT,
        S_DONE
    } state_t;

    function automatic logic is_blank(input logic [CHAR_W-1:0] ch);
        return (ch == CHAR_SPACE) || (ch == CHAR_TAB);
    endfunction

endpackage

// ===== rtl/line_editor_word_wrap.sv =====
// Line editor with word-wrapped cursor layout: text memory, edit decode,
// ctrl-W backward scan and layout walk. Depends on lewr_pkg.
// Usage:
//   Input channel (in_valid/in_ready, key_code) takes one key byte per beat.
//   Output channel (out_valid/out_ready) gives one beat per key: status,
//   text_length, cursor_row, cursor_col.
//   line_width_we/line_width_data write the wrap width; write only when idle.
// Timing:
//   An accepted key is decoded; a ctrl-W on a non-empty line then runs the
//   backward scan, after which the layout walk reads the characters held
//   after the edit and the result waits in S_DONE for the output register.
//   Both walks are set by the single read port of the text memory, one
//   character per cycle. The next key is taken the cycle after the result
//   enters the output register; no new key is taken while one is in work.
// Reset:
//   Length clears to zero and line width to 40; the text memory is not
//   cleared, only entries below the length are ever read.
// Stall:
//   While out_ready is low a finished result holds in the output register;
//   one more key may be accepted and waits with its result until the slot
//   frees up.
module line_editor_word_wrap (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           line_width_we,
    input  logic [lewr_pkg::WIDTH_W-1:0]   line_width_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [lewr_pkg::KEY_W-1:0]     key_code,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [lewr_pkg::STATUS_W-1:0]  status,
    output logic [lewr_pkg::LEN_OUT_W-1:0] text_length,
    output logic [lewr_pkg::ROW_W-1:0]     cursor_row,
    output logic [lewr_pkg::COL_W-1:0]     cursor_col
);
    import lewr_pkg::*;

    logic [CHAR_W-1:0] mem [TEXT_DEPTH];
    logic [CHAR_W-1:0] rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [CHAR_W-1:0] mem_wd;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_ra;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] len_reg, len_next;
    status_t           stat_reg, stat_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              rd_vld_reg, rd_vld_next;
    logic              ph_word_reg, ph_word_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [COL_W-1:0]  wl_reg, wl_next;
    logic              split_reg, split_next;
    logic [WIDTH_W-1:0] width_reg;

    logic                 out_valid_reg, out_valid_next;
    status_t              out_stat_reg;
    logic [LEN_OUT_W-1:0] out_len_reg;
    logic [ROW_W-1:0]     out_row_reg;
    logic [COL_W-1:0]     out_col_reg;

    logic              accept;
    logic              printable;
    logic              go_scan;
    logic [COL_W-1:0]  eff_w;
    logic              ch_blank;
    logic              scan_dec;
    logic              scan_stop;
    logic              walk_done;
    logic              out_load;
    logic [COL_W:0]    fit_sum;
    logic [ROW_W-1:0]  set_row;
    logic [COL_W-1:0]  set_col;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign printable = (key_code >= PRINT_LOW) && (key_code <= PRINT_HIGH);
    assign go_scan   = (key_code == KEY_WORD) && (len_reg != '0);
    assign eff_w     = (width_reg == '0) ? COL_W'(1) : width_reg;
    assign ch_blank  = is_blank(rdata_reg);
    assign scan_dec  = rd_vld_reg && !(ph_word_reg && ch_blank);
    assign scan_stop = rd_vld_reg && (!scan_dec || (len_reg == ADDR_W'(1)));
    assign walk_done = !mem_re && !rd_vld_reg;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // text memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_ra];
        end
    end

    assign mem_we = accept && printable && (len_reg < MAX_LEN);
    assign mem_wa = len_reg;
    assign mem_wd = key_code[CHAR_W-1:0];

    always_comb
    begin
        mem_re = 1'b0;
        mem_ra = idx_reg;
        if (state_reg == S_WSCAN)
        begin
            mem_re = (idx_reg != '0) && !scan_stop;
            mem_ra = idx_reg - ADDR_W'(1);
        end
        else if (state_reg == S_LAYOUT)
        begin
            mem_re = (idx_reg < len_reg);
            mem_ra = idx_reg;
        end
    end

    // pending word settled against the current row
    always_comb
    begin
        fit_sum = {1'b0, col_reg} + {1'b0, wl_reg};
        set_row = row_reg;
        set_col = col_reg;
        if (!split_reg)
        begin
            if (fit_sum <= {1'b0, eff_w})
            begin
                set_col = fit_sum[COL_W-1:0];
            end
            else
            begin
                set_row = row_reg + ROW_W'(1);
                set_col = wl_reg;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = go_scan ? S_WSCAN : S_LAYOUT;
                end
            end
            S_WSCAN:
            begin
                if (scan_stop)
                begin
                    state_next = S_LAYOUT;
                end
            end
            S_LAYOUT:
            begin
                if (walk_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        len_next       = len_reg;
        stat_next      = stat_reg;
        idx_next       = idx_reg;
        rd_vld_next    = mem_re;
        ph_word_next   = ph_word_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        wl_next        = wl_reg;
        split_next     = split_reg;
        out_valid_next = out_valid_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                stat_next    = STATUS_OK;
                idx_next     = '0;
                ph_word_next = 1'b0;
                row_next     = '0;
                col_next     = '0;
                wl_next      = '0;
                split_next   = 1'b0;
                if (accept)
                begin
                    unique case (key_code)
                        KEY_EOF:
                        begin
                            stat_next = (len_reg == '0) ? STATUS_EXIT : STATUS_BELL;
                        end
                        KEY_ERASE:
                        begin
                            if (len_reg != '0)
                                len_next = len_reg - ADDR_W'(1);
                            else
                                stat_next = STATUS_BELL;
                        end
                        KEY_KILL:
                        begin
                            if (len_reg != '0)
                                len_next = '0;
                            else
                                stat_next = STATUS_BELL;
                        end
                        KEY_WORD:
                        begin
                            if (len_reg != '0)
                                idx_next = len_reg;
                            else
                                stat_next = STATUS_BELL;
                        end
                        default:
                        begin
                            if (mem_we)
                                len_next = len_reg + ADDR_W'(1);
                            else
                                stat_next = STATUS_BELL;
                        end
                    endcase
                end
            end
            S_WSCAN:
            begin
                if (mem_re)
                begin
                    idx_next = idx_reg - ADDR_W'(1);
                end
                if (scan_dec)
                begin
                    len_next = len_reg - ADDR_W'(1);
                    if (!ch_blank)
                    begin
                        ph_word_next = 1'b1;
                    end
                end
                if (scan_stop)
                begin
                    idx_next    = '0;
                    rd_vld_next = 1'b0;
                end
            end
            S_LAYOUT:
            begin
                if (mem_re)
                begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
                if (rd_vld_reg)
                begin
                    if (ch_blank)
                    begin
                        wl_next    = '0;
                        split_next = 1'b0;
                        if (set_col >= eff_w)
                        begin
                            row_next = set_row + ROW_W'(1);
                            col_next = COL_W'(1);
                        end
                        else
                        begin
                            row_next = set_row;
                            col_next = set_col + COL_W'(1);
                        end
                    end
                    else if (split_reg)
                    begin
                        if (col_reg == eff_w)
                        begin
                            row_next = row_reg + ROW_W'(1);
                            col_next = COL_W'(1);
                        end
                        else
                        begin
                            col_next = col_reg + COL_W'(1);
                        end
                    end
                    else if (wl_reg == eff_w)
                    begin
                        // word outgrows a row: switch to splitting
                        split_next = 1'b1;
                        if (col_reg == eff_w)
                        begin
                            row_next = row_reg + ROW_W'(2);
                            col_next = COL_W'(1);
                        end
                        else
                        begin
                            row_next = row_reg + ROW_W'(1);
                            col_next = col_reg + COL_W'(1);
                        end
                    end
                    else
                    begin
                        wl_next = wl_reg + COL_W'(1);
                    end
                end
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            width_reg     <= WIDTH_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
            if (line_width_we)
            begin
                width_reg <= line_width_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        stat_reg    <= stat_next;
        idx_reg     <= idx_next;
        ph_word_reg <= ph_word_next;
        row_reg     <= row_next;
        col_reg     <= col_next;
        wl_reg      <= wl_next;
        split_reg   <= split_next;
        if (out_load)
        begin
            out_stat_reg <= stat_reg;
            out_len_reg  <= LEN_OUT_W'(len_reg);
            out_row_reg  <= set_row;
            out_col_reg  <= set_col;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_stat_reg;
    assign text_length = out_len_reg;
    assign cursor_row  = out_row_reg;
    assign cursor_col  = out_col_reg;

`ifndef SYNTHESIS
    a_write_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_IDLE) && in_valid)
        else $error("text write outside key accept");

    a_accept_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_WSCAN) || (state_reg == S_LAYOUT))
        else $error("accepted key did not start a walk");

    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LAYOUT) |-> (col_reg <= eff_w) && (wl_reg <= eff_w))
        else $error("layout column or word length beyond line width");

    a_scan_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WSCAN) |=> (len_reg <= $past(len_reg)))
        else $error("ctrl-W scan grew the length");
`endif

endmodule

// ===== tb/sv/lewr_checker.sv =====
`timescale 1ns / 100ps
// Checker for line_editor_word_wrap: watches the key and result channels,
// keeps its own text buffer and wrap width, predicts each result and compares.
// Depends on lewr_pkg.
module lewr_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           line_width_we,
    input  logic [lewr_pkg::WIDTH_W-1:0]   line_width_data,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [lewr_pkg::KEY_W-1:0]     key_code,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [lewr_pkg::STATUS_W-1:0]  status,
    input  logic [lewr_pkg::LEN_OUT_W-1:0] text_length,
    input  logic [lewr_pkg::ROW_W-1:0]     cursor_row,
    input  logic [lewr_pkg::COL_W-1:0]     cursor_col,
    output int                             fail_count,
    output int                             pending
);
    import lewr_pkg::*;

    typedef struct packed {
        status_t              status;
        logic [LEN_OUT_W-1:0] length;
        logic [ROW_W-1:0]     row;
        logic [COL_W-1:0]     col;
    } key_result_t;

    logic [CHAR_W-1:0]  line_text [TEXT_DEPTH];
    int unsigned        held;
    logic [WIDTH_W-1:0] wrap_width;
    key_result_t        result_q[$];

    function automatic bit is_gap(input logic [CHAR_W-1:0] ch);
        return (ch == CHAR_SPACE) || (ch == CHAR_TAB);
    endfunction

    // Walk the buffer and lay it out in rows of wrap_width columns.
    function automatic void locate_cursor(output int unsigned row, output int unsigned col);
        int unsigned w;
        int unsigned i;
        int unsigned e;
        int unsigned wl;
        int unsigned room;
        int unsigned chunk;
        w = (wrap_width == 0) ? 1 : wrap_width;
        row = 0;
        col = 0;
        i = 0;
        while (i < held)
        begin
            if (is_gap(line_text[ADDR_W'(i)]))
            begin
                if (col >= w)
                begin
                    row++;
                    col = 0;
                end
                col++;
                i++;
            end
            else
            begin
                e = i;
                while (e < held && !is_gap(line_text[ADDR_W'(e)]))
                    e++;
                wl = e - i;
                if (wl > w)
                begin
                    room = (col < w) ? (w - col) : 0;
                    if (room == 0)
                    begin
                        row++;
                        col = 0;
                        room = w;
                    end
                    chunk = (held - i < room) ? (held - i) : room;
                    col += chunk;
                    i += chunk;
                    if (col >= w)
                    begin
                        row++;
                        col = 0;
                    end
                end
                else if (col + wl > w)
                begin
                    row++;
                    col = wl;
                    i = e;
                end
                else
                begin
                    col += wl;
                    i = e;
                end
            end
        end
    endfunction

    function automatic key_result_t take_key(input logic [KEY_W-1:0] k);
        key_result_t r;
        int unsigned row;
        int unsigned col;
        int unsigned e;
        r.status = STATUS_OK;
        if (k == KEY_EOF && held == 0)
            r.status = STATUS_EXIT;
        else if (k == KEY_ERASE)
        begin
            if (held > 0)
                held--;
            else
                r.status = STATUS_BELL;
        end
        else if (k == KEY_KILL)
        begin
            if (held > 0)
                held = 0;
            else
                r.status = STATUS_BELL;
        end
        else if (k == KEY_WORD)
        begin
            if (held > 0)
            begin
                e = held;
                while (e > 0 && is_gap(line_text[ADDR_W'(e-1)]))
                    e--;
                while (e > 0 && !is_gap(line_text[ADDR_W'(e-1)]))
                    e--;
                held = e;
            end
            else
                r.status = STATUS_BELL;
        end
        else if (k < PRINT_LOW || k > PRINT_HIGH)
            r.status = STATUS_BELL;
        else if (held >= TEXT_DEPTH - 1)
            r.status = STATUS_BELL;
        else
        begin
            line_text[ADDR_W'(held)] = k[CHAR_W-1:0];
            held++;
        end
        locate_cursor(row, col);
        r.length = LEN_OUT_W'(held);
        r.row    = ROW_W'(row);
        r.col    = COL_W'(col);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        key_result_t want;
        if (!rst_n)
        begin
            held = 0;
            wrap_width = WIDTH_RESET;
            result_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (line_width_we)
                wrap_width = line_width_data;
            // result beat first: it belongs to a key taken earlier
            if (out_valid && out_ready)
            begin
                if (result_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat: status %0d len %0d row %0d col %0d",
                                 status, text_length, cursor_row, cursor_col);
                end
                else
                begin
                    want = result_q.pop_front();
                    if (status !== want.status || text_length !== want.length ||
                        cursor_row !== want.row || cursor_col !== want.col)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("mismatch: expected status %0d len %0d row %0d col %0d",
                                     want.status, want.length, want.row, want.col);
                            $display("          got status %0d len %0d row %0d col %0d",
                                     status, text_length, cursor_row, cursor_col);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
                result_q.push_back(take_key(key_code));
            pending = result_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_line_editor_word_wrap.sv =====
`timescale 1ns / 100ps
// Top of the line_editor_word_wrap testbench: clock, reset, key stimulus,
// wrap width writes, result-side stalls and the verdict.
// Depends on lewr_pkg, lewr_checker and the block itself.
module tb_line_editor_word_wrap;
    import lewr_pkg::*;

    localparam int CYCLE_LIMIT   = 12_000_000;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = TEXT_DEPTH + 16;

    localparam logic [KEY_W-1:0] KEY_SPACE = 8'h20;
    localparam logic [KEY_W-1:0] KEY_TAB   = 8'h09;
    localparam logic [KEY_W-1:0] KEY_NUL   = 8'h00;
    localparam logic [KEY_W-1:0] KEY_US    = 8'h1F;
    localparam logic [KEY_W-1:0] KEY_HIGH  = 8'h80;
    localparam logic [KEY_W-1:0] KEY_ALL   = 8'hFF;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 line_width_we;
    logic [WIDTH_W-1:0]   line_width_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [KEY_W-1:0]     key_code;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic [LEN_OUT_W-1:0] text_length;
    logic [ROW_W-1:0]     cursor_row;
    logic [COL_W-1:0]     cursor_col;

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_idle_pct;
    int keys_sent;
    int cycles = 0;
    bit hold_go;
    int hold_left = 0;
    bit hold_done = 1'b0;

    line_editor_word_wrap u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .line_width_we   (line_width_we),
        .line_width_data (line_width_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .key_code        (key_code),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .text_length     (text_length),
        .cursor_row      (cursor_row),
        .cursor_col      (cursor_col)
    );

    lewr_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .line_width_we   (line_width_we),
        .line_width_data (line_width_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .key_code        (key_code),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .text_length     (text_length),
        .cursor_row      (cursor_row),
        .cursor_col      (cursor_col),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_go && !hold_done)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Returns right after the accepting rising edge; valid stays up until
    // the next call or drop_valid decides at the following falling edge.
    task automatic send_key(input logic [KEY_W-1:0] k);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        key_code <= k;
        do
            @(posedge clk);
        while (!in_ready);
        keys_sent++;
    endtask

    task automatic drop_valid();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        drop_valid();
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic set_width(input logic [WIDTH_W-1:0] w);
        drain();
        repeat (8) @(negedge clk);
        line_width_we   <= 1'b1;
        line_width_data <= w;
        @(negedge clk);
        line_width_we   <= 1'b0;
    endtask

    task automatic send_word(input int len);
        repeat (len) send_key(KEY_W'($urandom_range(33, 126)));
    endtask

    // Typed lines: words and blanks with edits mixed in, a few stray bytes,
    // each line closed by kill, word erase or erase runs.
    task automatic type_lines(input int n);
        int start;
        int pick;
        int words;
        start = keys_sent;
        while (keys_sent - start < n)
        begin
            words = $urandom_range(1, 10);
            while (words > 0 && keys_sent - start < n)
            begin
                pick = $urandom_range(99);
                if (pick < 10)
                    send_key(KEY_W'($urandom_range(0, 255)));
                else if (pick < 18)
                    send_key(KEY_ERASE);
                else if (pick < 22)
                    send_key(KEY_WORD);
                if ($urandom_range(9) == 0)
                    send_word($urandom_range(1, 70));
                else
                    send_word($urandom_range(1, 9));
                repeat ($urandom_range(1, 3)) send_key(KEY_SPACE);
                words--;
            end
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                send_key(KEY_KILL);
                if ($urandom_range(2) == 0)
                    send_key(KEY_EOF);
            end
            else if (pick < 80)
                repeat ($urandom_range(1, 4)) send_key(KEY_WORD);
            else
            begin
                repeat ($urandom_range(1, 6)) send_key(KEY_ERASE);
                send_key(KEY_KILL);
            end
        end
    endtask

    initial
    begin
        line_width_we   = 1'b0;
        line_width_data = '0;
        in_valid        = 1'b0;
        key_code        = '0;
        hold_go         = 1'b0;
        keys_sent       = 0;
        send_idle_pct   = 10;
        recv_idle_pct   = 79;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty-line controls, refused codes, blanks, word erase
        send_key(KEY_EOF);
        send_key(KEY_ERASE);
        send_key(KEY_KILL);
        send_key(KEY_WORD);
        send_key(KEY_NUL);
        send_key(KEY_ALL);
        send_key(KEY_HIGH);
        send_key(KEY_TAB);
        send_key(KEY_US);
        send_key(PRINT_LOW);
        send_key(PRINT_HIGH);
        send_key(8'h61);
        send_key(KEY_SPACE);
        send_key(KEY_SPACE);
        send_key(KEY_WORD);
        send_key(KEY_EOF);
        send_key(KEY_ERASE);
        send_key(8'h5A);
        send_key(KEY_ERASE);
        send_key(8'h51);
        send_key(KEY_KILL);
        send_key(KEY_EOF);

        set_width(8'd1);
        type_lines(30);
        set_width(8'd255);
        type_lines(30);

        send_idle_pct = 79;
        recv_idle_pct = 10;
        set_width(8'd0);
        type_lines(25);
        set_width(WIDTH_W'($urandom_range(2, 20)));
        type_lines(35);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_width(8'd7);
        hold_go = 1'b1;
        type_lines(25);
        drain();
        type_lines(20);

        set_width(WIDTH_W'($urandom_range(1, 255)));
        type_lines(45);

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lewr_pkg.sv
rtl/line_editor_word_wrap.sv
tb/sv/lewr_checker.sv
tb/sv/tb_line_editor_word_wrap.sv
